// ===== rtl/sync_framed_packet_crc8_checker_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sync framed packet CRC-8 checker
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef SYNC_FRAMED_PACKET_CRC8_CHECKER_MACROS_SVH
`define SYNC_FRAMED_PACKET_CRC8_CHECKER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SFPC8_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sfpc8 assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SFPC8_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sfpc8 assertion failed");

`endif

// ===== rtl/sfpc8_pkg.sv =====
// ----------------------------------------------------------------------------
// sfpc8_pkg
// Constants and types shared by the sync framed packet CRC-8 checker.
// ----------------------------------------------------------------------------
package sfpc8_pkg;

   localparam int BYTE_W        = 8;
   localparam int PACKET_LEN    = 8;
   localparam int PAYLOAD_LEN   = PACKET_LEN - 2;
   localparam int PAYLOAD_BYTES = 6;
   localparam int PAYLOAD_W     = PAYLOAD_BYTES * BYTE_W;
   localparam int POS_W         = $clog2(PACKET_LEN + 1);

   localparam logic [BYTE_W-1:0] CRC_POLY   = 8'h07;
   localparam logic [BYTE_W-1:0] CRC_TOP    = 8'h80;
   localparam logic [BYTE_W-1:0] CRC_INIT   = 8'h00;
   localparam logic [BYTE_W-1:0] SYNC_RESET = 8'd170;

   // One result beat as it leaves the framer.
   typedef struct packed {
      logic [BYTE_W-1:0]    byte_out;
      logic                 forward_byte;
      logic                 packet_valid;
      logic [PAYLOAD_W-1:0] payload;
   } result_type;

endpackage

// ===== rtl/sync_framed_packet_crc8_checker.sv =====
// ----------------------------------------------------------------------------
// sync_framed_packet_crc8_checker
// Hunts for the sync byte, collects fixed-length packets and checks the
// trailing CRC-8; every byte yields one result beat.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_byte_in
//   rsp      out        rsp_valid/rsp_stall   rsp_byte_out, rsp_forward_byte,
//                                              rsp_packet_valid, rsp_payload
//   csr      in         csr_write_enable      csr_write_data (sync value)
//
// One byte is taken every cycle while req_stall is low; each result passes
// through the input register and then the result register.
// The framer state (position, running CRC, payload store) advances when a byte
// moves from the input register into the result register.
// Reset clears both stage valids, the packet position and CRC, and loads the
// sync value with 170. A stalled result holds; the input register still takes
// one further beat, and req_stall rises only when both registers are full.
//
module sync_framed_packet_crc8_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [sfpc8_pkg::BYTE_W-1:0]         req_byte_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [sfpc8_pkg::BYTE_W-1:0]         rsp_byte_out,
   output logic                                 rsp_forward_byte,
   output logic                                 rsp_packet_valid,
   output logic [sfpc8_pkg::PAYLOAD_W-1:0]      rsp_payload,
   input  logic                                 csr_write_enable,
   input  logic [sfpc8_pkg::BYTE_W-1:0]         csr_write_data
);
   import sfpc8_pkg::*;

   logic [BYTE_W-1:0] sync_value_ff;
   logic              in_valid_ff;
   logic              in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   result_type        rsp_ff;
   result_type        result;
   logic              req_take;
   logic              advance;

   // The sync register only matters at the next hunt, so it is written at once.
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_value_ff <= SYNC_RESET;
      end else if (csr_write_enable) begin
         sync_value_ff <= csr_write_data;
      end
   end

   // A byte leaves the input register whenever the result register is empty
   // or is being emptied in this cycle.
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_byte_in;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   sfpc8_framer u_framer (
      .clock      (clock),
      .reset      (reset),
      .fire       (advance),
      .byte_in    (in_byte_ff),
      .sync_value (sync_value_ff),
      .result     (result)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_byte_out     = rsp_ff.byte_out;
   assign rsp_forward_byte = rsp_ff.forward_byte;
   assign rsp_packet_valid = rsp_ff.packet_valid;
   assign rsp_payload      = rsp_ff.payload;

endmodule

// ===== rtl/sfpc8_crc8.sv =====
// ----------------------------------------------------------------------------
// sfpc8_crc8
// One-byte CRC-8 update, polynomial 0x07, most significant bit first.
// ----------------------------------------------------------------------------
module sfpc8_crc8 (
   input  logic [sfpc8_pkg::BYTE_W-1:0] crc_cur,
   input  logic [sfpc8_pkg::BYTE_W-1:0] data,
   output logic [sfpc8_pkg::BYTE_W-1:0] crc_nxt
);
   import sfpc8_pkg::*;

   always_comb begin
      logic [BYTE_W-1:0] c;
      c = crc_cur ^ data;
      for (int k = 0; k < BYTE_W; k++) begin
         if ((c & CRC_TOP) != '0) begin
            c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[BYTE_W-2:0], 1'b0};
         end
      end
      crc_nxt = c;
   end

endmodule

// ===== rtl/sfpc8_framer.sv =====
// ----------------------------------------------------------------------------
// sfpc8_framer
// Packet position, running CRC and payload store; forms one result per byte.
// ----------------------------------------------------------------------------
module sfpc8_framer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  logic [sfpc8_pkg::BYTE_W-1:0]  byte_in,
   input  logic [sfpc8_pkg::BYTE_W-1:0]  sync_value,
   output sfpc8_pkg::result_type         result
);
   import sfpc8_pkg::*;

   logic [POS_W-1:0]     pos_ff;
   logic [POS_W-1:0]     pos_in;
   logic [BYTE_W-1:0]    crc_ff;
   logic [BYTE_W-1:0]    crc_in;
   logic [BYTE_W-1:0]    crc_base;
   logic [BYTE_W-1:0]    crc_upd;
   logic [BYTE_W-1:0]    store_ff [PAYLOAD_LEN];
   logic [PAYLOAD_W-1:0] pay_all;
   logic                 hunting;
   logic                 last;
   logic                 middle;
   logic                 sync_hit;
   logic                 crc_ok;

   assign hunting  = (pos_ff == '0) || (pos_ff >= POS_W'(PACKET_LEN));
   assign last     = !hunting && (pos_ff == POS_W'(PACKET_LEN - 1));
   assign middle   = !hunting && !last;
   assign sync_hit = (byte_in == sync_value);
   assign crc_ok   = last && (crc_ff == byte_in);
   assign crc_base = hunting ? CRC_INIT : crc_ff;

   sfpc8_crc8 u_crc8 (
      .crc_cur (crc_base),
      .data    (byte_in),
      .crc_nxt (crc_upd)
   );

   always_comb begin
      pos_in = pos_ff;
      crc_in = crc_ff;
      priority if (hunting) begin
         pos_in = sync_hit ? POS_W'(1) : '0;
         if (sync_hit) begin
            crc_in = crc_upd;
         end
      end else if (middle) begin
         pos_in = pos_ff + POS_W'(1);
         crc_in = crc_upd;
      end else begin
         pos_in = '0;
         crc_in = CRC_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         crc_ff <= CRC_INIT;
      end else if (fire) begin
         pos_ff <= pos_in;
         crc_ff <= crc_in;
      end
   end

   // Each payload entry is written when its own position comes by.
   for (genvar g = 0; g < PAYLOAD_LEN; g++) begin : g_store
      always_ff @(posedge clock) begin
         if (fire && middle && (pos_ff == POS_W'(g + 1))) begin
            store_ff[g] <= byte_in;
         end
      end
   end

   for (genvar g = 0; g < PAYLOAD_BYTES; g++) begin : g_pay
      if (g < PAYLOAD_LEN) begin : g_used
         assign pay_all[g*BYTE_W +: BYTE_W] = store_ff[g];
      end else begin : g_unused
         assign pay_all[g*BYTE_W +: BYTE_W] = '0;
      end
   end

   always_comb begin
      result.byte_out     = byte_in;
      result.forward_byte = !crc_ok;
      result.packet_valid = crc_ok;
      result.payload      = crc_ok ? pay_all : '0;
   end

endmodule

// ===== rtl/sfpc8_checker.sv =====
// ----------------------------------------------------------------------------
// sfpc8_checker
// Port-level assertions for the sync framed packet CRC-8 checker, bound
// to the top level.
// ----------------------------------------------------------------------------
`include "sync_framed_packet_crc8_checker_macros.svh"

module sfpc8_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic [sfpc8_pkg::BYTE_W-1:0]         rsp_byte_out,
   input logic                                 rsp_forward_byte,
   input logic                                 rsp_packet_valid,
   input logic [sfpc8_pkg::PAYLOAD_W-1:0]      rsp_payload
);
   import sfpc8_pkg::*;

   logic [BYTE_W+2+PAYLOAD_W-1:0] rsp_content;
   assign rsp_content = {rsp_byte_out, rsp_forward_byte, rsp_packet_valid, rsp_payload};

   // A stalled result beat stays and keeps its contents.
   `SFPC8_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_content))

   // The input side stalls only when the result side is full and held.
   `SFPC8_ASSERT_SAME(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)

   // A byte that completes a good packet is never forwarded, and vice versa.
   `SFPC8_ASSERT_SAME(a_fwd_excl, clock, reset, rsp_valid, rsp_forward_byte != rsp_packet_valid)

   // Payload is zero on every beat that does not complete a good packet.
   `SFPC8_ASSERT_SAME(a_pay_zero, clock, reset, rsp_valid && !rsp_packet_valid, rsp_payload == '0)

endmodule

bind sync_framed_packet_crc8_checker sfpc8_checker u_sfpc8_checker (.*);

// ===== tb/sv/sfpc8_frame_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfpc8_frame_checker
// Watches the byte and result channels of the sync framed CRC-8 checker,
// predicts every result beat from the accepted bytes and compares them.
// ----------------------------------------------------------------------------
module sfpc8_frame_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [sfpc8_pkg::BYTE_W-1:0]    req_byte_in,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [sfpc8_pkg::BYTE_W-1:0]    rsp_byte_out,
   input  logic                            rsp_forward_byte,
   input  logic                            rsp_packet_valid,
   input  logic [sfpc8_pkg::PAYLOAD_W-1:0] rsp_payload,
   input  logic                            csr_write_enable,
   input  logic [sfpc8_pkg::BYTE_W-1:0]    csr_write_data,
   output int                              failures,
   output int                              outstanding,
   output int                              beats_checked,
   output int                              packets_passed
);
   import sfpc8_pkg::*;

   localparam int BODY_IDX_W = $clog2(PAYLOAD_LEN);

   // Private copy of the framer state and of the sync register.
   logic [BYTE_W-1:0] sync_byte;
   logic [POS_W-1:0]  frame_pos;
   logic [BYTE_W-1:0] frame_crc;
   logic [BYTE_W-1:0] frame_body [PAYLOAD_LEN];

   result_type expected_beats [$];

   initial begin
      failures       = 0;
      outstanding    = 0;
      beats_checked  = 0;
      packets_passed = 0;
   end

   function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                     input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] c;
      int                k;
      c = crc ^ b;
      for (k = 0; k < 8; k++) begin
         if ((c & CRC_TOP) != '0) begin
            c = (c << 1) ^ CRC_POLY;
         end else begin
            c = c << 1;
         end
      end
      return c;
   endfunction

   // Advances the framer by one byte and returns the beat it should produce.
   function automatic result_type frame_step(input logic [BYTE_W-1:0] b);
      result_type r;
      int         i;
      r.byte_out     = b;
      r.forward_byte = 1'b1;
      r.packet_valid = 1'b0;
      r.payload      = '0;
      if (frame_pos == 0 || frame_pos >= PACKET_LEN) begin
         frame_pos = '0;
         if (b == sync_byte) begin
            frame_crc = crc8_update(CRC_INIT, b);
            frame_pos = POS_W'(1);
         end
      end else if (frame_pos < PACKET_LEN - 1) begin
         frame_body[BODY_IDX_W'(frame_pos - POS_W'(1))] = b;
         frame_crc = crc8_update(frame_crc, b);
         frame_pos = frame_pos + 1'b1;
      end else begin
         if (frame_crc == b) begin
            for (i = 0; i < PAYLOAD_LEN && i < PAYLOAD_BYTES; i++) begin
               r.payload[8*i +: 8] = frame_body[i];
            end
            r.packet_valid = 1'b1;
            r.forward_byte = 1'b0;
         end
         frame_pos = '0;
         frame_crc = CRC_INIT;
      end
      return r;
   endfunction

   task automatic note_failure(input string what, input result_type want);
      failures++;
      if (failures <= 10) begin
         $write("%s at beat %0d: byte_out exp %02h got %02h, forward exp %0b got %0b, ",
                what, beats_checked, want.byte_out, rsp_byte_out,
                want.forward_byte, rsp_forward_byte);
         $display("valid exp %0b got %0b, payload exp %012h got %012h",
                  want.packet_valid, rsp_packet_valid, want.payload, rsp_payload);
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         sync_byte = SYNC_RESET;
         frame_pos = '0;
         frame_crc = CRC_INIT;
         expected_beats.delete();
         outstanding <= 0;
      end else begin
         if (csr_write_enable) begin
            sync_byte = csr_write_data;
         end
         if (req_valid && !req_stall) begin
            expected_beats.push_back(frame_step(req_byte_in));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_beats.size() == 0) begin
               want = '0;
               note_failure("unexpected result", want);
            end else begin
               want = expected_beats.pop_front();
               if (rsp_byte_out !== want.byte_out ||
                   rsp_forward_byte !== want.forward_byte ||
                   rsp_packet_valid !== want.packet_valid ||
                   rsp_payload !== want.payload) begin
                  note_failure("mismatch", want);
               end
               if (want.packet_valid) begin
                  packets_passed <= packets_passed + 1;
               end
            end
            beats_checked <= beats_checked + 1;
         end
         outstanding <= expected_beats.size();
      end
   end

endmodule

// ===== tb/sv/tb_sync_framed_packet_crc8_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sync_framed_packet_crc8_checker
// Drives byte beats into the sync framed CRC-8 checker under random flow
// control and several sync settings; a checker module predicts and compares.
// ----------------------------------------------------------------------------
module tb_sync_framed_packet_crc8_checker;
   import sfpc8_pkg::*;

   localparam int FRAME_W = PACKET_LEN * BYTE_W;
   localparam int BODY_W  = PAYLOAD_LEN * BYTE_W;

   // Every input of the block starts from a known value, with reset high.
   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 req_valid        = 1'b0;
   logic [BYTE_W-1:0]    req_byte_in      = '0;
   logic                 rsp_stall        = 1'b0;
   logic                 csr_write_enable = 1'b0;
   logic [BYTE_W-1:0]    csr_write_data   = '0;

   logic                 req_stall;
   logic                 rsp_valid;
   logic [BYTE_W-1:0]    rsp_byte_out;
   logic                 rsp_forward_byte;
   logic                 rsp_packet_valid;
   logic [PAYLOAD_W-1:0] rsp_payload;

   int failures;
   int outstanding;
   int beats_checked;
   int packets_passed;

   // Stimulus bookkeeping for the summary and the idling pattern.
   int   bytes_sent    = 0;
   int   sync_settings = 1;
   logic sender_quiet  = 1'b0;

   sync_framed_packet_crc8_checker u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_byte_in      (req_byte_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_byte_out     (rsp_byte_out),
      .rsp_forward_byte (rsp_forward_byte),
      .rsp_packet_valid (rsp_packet_valid),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   sfpc8_frame_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_byte_in      (req_byte_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_byte_out     (rsp_byte_out),
      .rsp_forward_byte (rsp_forward_byte),
      .rsp_packet_valid (rsp_packet_valid),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .failures         (failures),
      .outstanding      (outstanding),
      .beats_checked    (beats_checked),
      .packets_passed   (packets_passed)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // A generous ceiling on the run time, so a stuck handshake ends the run here.
   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // CRC-8 used only to build well-formed frames; the checker keeps its own.
   function automatic logic [BYTE_W-1:0] crc8_advance(input logic [BYTE_W-1:0] crc,
                                                      input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] c;
      int                k;
      c = crc ^ b;
      for (k = 0; k < 8; k++) begin
         if ((c & CRC_TOP) != '0) begin
            c = (c << 1) ^ CRC_POLY;
         end else begin
            c = c << 1;
         end
      end
      return c;
   endfunction

   // Lays out sync, payload and trailer with the first byte in bits 7:0. A
   // non-zero crc_flip spoils the trailer on purpose.
   function automatic logic [FRAME_W-1:0] make_frame(input logic [BYTE_W-1:0] sync,
                                                     input logic [BODY_W-1:0] body,
                                                     input logic [BYTE_W-1:0] crc_flip);
      logic [FRAME_W-1:0] f;
      logic [BYTE_W-1:0]  crc;
      int                 i;
      f[BYTE_W-1:0] = sync;
      crc = crc8_advance(CRC_INIT, sync);
      for (i = 0; i < PAYLOAD_LEN; i++) begin
         f[8*(i+1) +: 8] = body[8*i +: 8];
         crc = crc8_advance(crc, body[8*i +: 8]);
      end
      f[8*(PACKET_LEN-1) +: 8] = crc ^ crc_flip;
      return f;
   endfunction

   // Random payload in which roughly one byte in eight repeats the sync value,
   // so that a sync byte inside a packet turns up often.
   function automatic logic [BODY_W-1:0] random_body(input logic [BYTE_W-1:0] sync);
      logic [BODY_W-1:0] body;
      int                i;
      for (i = 0; i < PAYLOAD_LEN; i++) begin
         if ($urandom_range(0, 7) == 0) begin
            body[8*i +: 8] = sync;
         end else begin
            body[8*i +: 8] = BYTE_W'($urandom_range(0, 255));
         end
      end
      return body;
   endfunction

   // Sends one byte beat. It is entered just after a rising edge and returns at
   // the edge where the beat was taken, so back-to-back calls keep valid high
   // without lowering it in between. The idle gap is drawn per beat.
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      int gap;
      gap = sender_quiet ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_byte_in <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_frame(input logic [FRAME_W-1:0] f, input int first, input int last);
      int i;
      for (i = first; i <= last; i++) begin
         send_byte(f[8*i +: 8]);
      end
   endtask

   // Drops valid and waits until the checker has seen every result. The
   // counter it reads is registered, hence the edge before the wait. The
   // trailing wait covers the two pipeline stages before the register is touched.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_sync(input logic [BYTE_W-1:0] value);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sync_settings++;
   endtask

   // One phase of random traffic under a given sync value. Most of it is
   // well-formed frames so that the framer keeps reaching the CRC compare;
   // the rest is spoilt trailers, truncated frames and loose noise.
   task automatic random_phase(input logic [BYTE_W-1:0] sync, input int budget);
      int start;
      int pick;
      int n;
      int i;
      start = bytes_sent;
      while (bytes_sent - start < budget) begin
         sender_quiet = ($urandom_range(0, 5) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            send_frame(make_frame(sync, random_body(sync), '0), 0, PACKET_LEN - 1);
         end else if (pick < 80) begin
            send_frame(make_frame(sync, random_body(sync), BYTE_W'($urandom_range(1, 255))),
                       0, PACKET_LEN - 1);
         end else if (pick < 90) begin
            // A frame cut short: later bytes will be swallowed as its tail.
            n = $urandom_range(1, PACKET_LEN - 3);
            send_frame(make_frame(sync, random_body(sync), '0), 0, n);
         end else begin
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++) begin
               send_byte(BYTE_W'($urandom_range(0, 255)));
            end
         end
      end
   endtask

   // The result side: before each beat it holds stall high for a drawn number
   // of cycles, then waits with stall low until a beat is taken. Now and then
   // a stretch of beats runs with no stall at all.
   initial begin
      int hold;
      int run_left;
      logic quiet;
      quiet    = 1'b0;
      run_left = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (run_left == 0) begin
            quiet    = ($urandom_range(0, 4) == 0);
            run_left = $urandom_range(10, 60);
         end
         run_left--;
         hold = quiet ? 0 : $urandom_range(0, 12);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // Main sequence: reset, a short directed part, then random phases under
   // several sync values, and finally the drain and the verdict.
   initial begin
      logic [BODY_W-1:0]  edge_body;
      logic [FRAME_W-1:0] split_frame;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Bytes seen while hunting, at both extremes of the byte range.
      send_byte(8'h00);
      send_byte(8'hFF);

      // A good frame under the reset sync value whose payload holds both
      // extremes and the sync value itself, which must not restart the frame.
      edge_body = {8'h55, 8'hFF, SYNC_RESET, 8'h80, 8'h00, 8'h01};
      send_frame(make_frame(SYNC_RESET, edge_body, '0), 0, PACKET_LEN - 1);

      // A spoilt trailer: the framer goes back to hunting without a rescan.
      send_frame(make_frame(SYNC_RESET, random_body(SYNC_RESET), 8'h01), 0, PACKET_LEN - 1);

      // The sync value changes while a frame is half collected. The frame
      // that began under the old value still completes with a good CRC.
      split_frame = make_frame(SYNC_RESET, {PAYLOAD_LEN{8'hFF}}, '0);
      send_frame(split_frame, 0, 3);
      write_sync(8'h3C);
      send_frame(split_frame, 4, PACKET_LEN - 1);

      random_phase(8'h3C, 200);
      write_sync(8'h00);
      random_phase(8'h00, 205);
      write_sync(8'hFF);
      random_phase(8'hFF, 205);
      begin
         logic [BYTE_W-1:0] any_sync;
         any_sync = BYTE_W'($urandom_range(0, 255));
         write_sync(any_sync);
         random_phase(any_sync, 205);
      end
      write_sync(SYNC_RESET);
      random_phase(SYNC_RESET, 205);

      // Drain, then a short tail in case a stray beat follows.
      wait_idle();
      repeat (10) @(posedge clock);

      $display("Sent %0d byte beats under %0d sync settings with random stalls on both sides.",
               bytes_sent, sync_settings);
      $display("Checked %0d result beats, %0d packets passed CRC, %0d failures.",
               beats_checked, packets_passed, failures);
      if (failures == 0 && outstanding == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/sfpc8_pkg.sv
rtl/sfpc8_crc8.sv
rtl/sfpc8_framer.sv
rtl/sync_framed_packet_crc8_checker.sv
rtl/sfpc8_checker.sv
tb/sv/sfpc8_frame_checker.sv
tb/sv/tb_sync_framed_packet_crc8_checker.sv
